FILE: hw/rtl/vls_pkg.sv
package vls_pkg;

  localparam int MAX_LIGHTS = 8;
  localparam int IDX_W      = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int CMP_W      = 6;

  localparam int ACC_W      = 15;
  localparam int SUM_W      = 18;
  localparam int DOT_W      = 34;
  localparam int DOT_MAG_W  = 30;
  localparam int PG_W       = 32;
  localparam int PROD_W     = DOT_MAG_W + PG_W;
  localparam int TERM_LSB   = 42;
  localparam int TERM_W     = PROD_W - TERM_LSB;
  localparam int ACC_SUM_W  = TERM_W + 1;
  localparam int SCALE_W    = 8 + ACC_W;

  localparam logic [ACC_W-1:0] ONE_Q14    = 15'd16384;
  localparam logic [ACC_W-1:0] INV_SQRT2  = 15'd11585;
  localparam logic [ACC_W-1:0] INV_SQRT3  = 15'd9459;
  localparam logic [ACC_W-1:0] TOTAL_MAX  = 15'd24576;
  localparam logic [ACC_W-1:0] AMB_MAX    = 15'd16384;
  localparam logic [ACC_W-1:0] AMB_RESET  = 15'd2458;
  localparam logic [15:0]      GAIN_MAX   = 16'd32768;
  localparam logic [15:0]      GAIN_RESET = 16'd13107;
  localparam logic [3:0]       CNT_RESET  = 4'd0;

  localparam logic [1:0] REG_AMBIENT = 2'd0;
  localparam logic [1:0] REG_GAIN    = 2'd1;
  localparam logic [1:0] REG_COUNT   = 2'd2;

  localparam logic OP_SHADE = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  localparam logic ST_SHADED  = 1'b0;
  localparam logic ST_MISSING = 1'b1;

  typedef struct packed {
    logic signed [1:0] sx;
    logic signed [1:0] sy;
    logic signed [1:0] sz;
    logic [ACC_W-1:0]  mag;
  } norm_t;

  typedef struct packed {
    logic               valid;
    logic               op;
    logic [2:0]         slot;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [15:0]        power;
    logic               present;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    norm_t              norm;
    logic [ACC_W-1:0]   acc;
  } tok_t;

  function automatic norm_t face_normal(input logic [5:0] m);
    norm_t n;
    logic [1:0] k;
    n.sx = signed'(2'({1'b0, m[3]}) - 2'({1'b0, m[2]}));
    n.sy = signed'(2'({1'b0, m[0]}) - 2'({1'b0, m[1]}));
    n.sz = signed'(2'({1'b0, m[4]}) - 2'({1'b0, m[5]}));
    k = 2'(m[3] ^ m[2]) + 2'(m[0] ^ m[1]) + 2'(m[4] ^ m[5]);
    unique case (k)
      2'd1:    n.mag = ONE_Q14;
      2'd2:    n.mag = INV_SQRT2;
      2'd3:    n.mag = INV_SQRT3;
      default: n.mag = '0;
    endcase
    return n;
  endfunction

endpackage

FILE: hw/rtl/vls_cell.sv
module vls_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       active_i,
  input  logic [vls_pkg::IDX_W-1:0]  cell_idx_i,
  input  logic [15:0]                gain_i,
  input  vls_pkg::tok_t              tok_i,
  output vls_pkg::tok_t              tok_o
);
  import vls_pkg::*;

  logic signed [15:0]      ent_x_q, ent_y_q, ent_z_q;
  logic [15:0]             ent_pow_q;
  logic [PG_W-1:0]         pg_q;
  tok_t                    tok_a_q, tok_b_q, tok_b_d;
  logic signed [DOT_W-1:0] dot_q, dot_d;
  logic signed [SUM_W-1:0] tx, ty, tz, sum_d;
  logic                    wr_en;
  logic [PROD_W-1:0]       prod;
  logic [TERM_W-1:0]       term;
  logic [ACC_SUM_W-1:0]    acc_sum;
  logic                    use_term;

  function automatic logic signed [SUM_W-1:0] pick(input logic signed [1:0] s,
                                                   input logic signed [15:0] d);
    logic signed [SUM_W-1:0] r;
    if (s == 2'sd1) begin
      r = SUM_W'(d);
    end else if (s == -2'sd1) begin
      r = -SUM_W'(d);
    end else begin
      r = '0;
    end
    return r;
  endfunction

  assign wr_en = adv_i && tok_i.valid && (tok_i.op == OP_LOAD) &&
                 (CMP_W'(tok_i.slot) == CMP_W'(cell_idx_i));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ent_x_q   <= tok_i.dir_x;
      ent_y_q   <= tok_i.dir_y;
      ent_z_q   <= tok_i.dir_z;
      ent_pow_q <= tok_i.power;
    end
    pg_q <= PG_W'(ent_pow_q) * PG_W'(gain_i);
  end

  always_comb begin
    tx    = pick(tok_i.norm.sx, ent_x_q);
    ty    = pick(tok_i.norm.sy, ent_y_q);
    tz    = pick(tok_i.norm.sz, ent_z_q);
    sum_d = tx + ty + tz;
    dot_d = DOT_W'(sum_d) * DOT_W'(signed'({1'b0, tok_i.norm.mag}));
  end

  always_comb begin
    prod     = PROD_W'(dot_q[DOT_MAG_W-1:0]) * PROD_W'(pg_q);
    term     = prod[PROD_W-1:TERM_LSB];
    use_term = (tok_a_q.op == OP_SHADE) && tok_a_q.present && active_i && (dot_q > 0);
    acc_sum  = ACC_SUM_W'(tok_a_q.acc) + (use_term ? ACC_SUM_W'(term) : '0);
    tok_b_d  = tok_a_q;
    if (acc_sum > ACC_SUM_W'(TOTAL_MAX)) begin
      tok_b_d.acc = TOTAL_MAX;
    end else begin
      tok_b_d.acc = acc_sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_a_q <= '0;
      tok_b_q <= '0;
    end else if (adv_i) begin
      tok_a_q <= tok_i;
      tok_b_q <= tok_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dot_q <= dot_d;
    end
  end

  assign tok_o = tok_b_q;

endmodule

FILE: hw/rtl/vls_out.sv
module vls_out (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  vls_pkg::tok_t tok_i,
  output logic          out_valid_o,
  output logic          status_o,
  output logic [7:0]    out_red_o,
  output logic [7:0]    out_green_o,
  output logic [7:0]    out_blue_o,
  output logic [7:0]    out_alpha_o
);
  import vls_pkg::*;

  logic       valid_q;
  logic       status_q, status_d;
  logic [7:0] red_q, green_q, blue_q, alpha_q;
  logic [7:0] red_d, green_d, blue_d, alpha_d;

  function automatic logic [7:0] scale(input logic [7:0] c, input logic [ACC_W-1:0] t);
    logic [SCALE_W-1:0] p;
    logic [SCALE_W-15:0] v;
    p = SCALE_W'(c) * SCALE_W'(t);
    v = p[SCALE_W-1:14];
    return (v > (SCALE_W-14)'(255)) ? 8'd255 : v[7:0];
  endfunction

  always_comb begin
    if (tok_i.present) begin
      status_d = ST_SHADED;
      red_d    = scale(tok_i.red, tok_i.acc);
      green_d  = scale(tok_i.green, tok_i.acc);
      blue_d   = scale(tok_i.blue, tok_i.acc);
      alpha_d  = tok_i.alpha;
    end else begin
      status_d = ST_MISSING;
      red_d    = '0;
      green_d  = '0;
      blue_d   = '0;
      alpha_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= tok_i.valid && (tok_i.op == OP_SHADE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      status_q <= status_d;
      red_q    <= red_d;
      green_q  <= green_d;
      blue_q   <= blue_d;
      alpha_q  <= alpha_d;
    end
  end

  assign out_valid_o = valid_q;
  assign status_o    = status_q;
  assign out_red_o   = red_q;
  assign out_green_o = green_q;
  assign out_blue_o  = blue_q;
  assign out_alpha_o = alpha_q;

endmodule

FILE: hw/rtl/voxel_lambert_shader_unit.sv
// Lambert diffuse plus ambient shading, one voxel per transfer.
// The input channel (in_valid_i / in_ready_o) carries either a shade item or
// a load item that writes one light slot. The output channel (out_valid_o /
// out_ready_i) carries one result for each shade item and none for a load.
// Items travel through a row of registered light cells, one per slot, and
// then through a registered output stage. One item is taken in every cycle
// while the output flows. Load items travel the same row, so they take effect
// in input order.
// The user must write the configuration registers (cfg_we_i, cfg_idx_i,
// cfg_data_i) only while no item is in flight; the block does not enforce it.
// Reset empties the row and loads the default ambient level, diffuse gain
// and a light count of zero; light slots hold no defined value until loaded.
// When the receiver stalls a waiting result, the whole row holds and in_ready_o
// falls, so nothing is lost; it rises again in the cycle that result is taken.
module voxel_lambert_shader_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [2:0]  light_slot_i,
  input  logic [15:0] light_dir_x_i,
  input  logic [15:0] light_dir_y_i,
  input  logic [15:0] light_dir_z_i,
  input  logic [15:0] light_power_i,
  input  logic        voxel_present_i,
  input  logic [7:0]  voxel_red_i,
  input  logic [7:0]  voxel_green_i,
  input  logic [7:0]  voxel_blue_i,
  input  logic [7:0]  voxel_alpha_i,
  input  logic [5:0]  exposed_faces_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_alpha_o
);
  import vls_pkg::*;

  logic [ACC_W-1:0] amb_q, amb_c;
  logic [15:0]      gain_q, gain_c;
  logic [3:0]       cnt_q;
  logic             adv;
  tok_t             tok_in;
  tok_t             chain [MAX_LIGHTS+1];
  logic [MAX_LIGHTS-1:0] active;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amb_q  <= AMB_RESET;
      gain_q <= GAIN_RESET;
      cnt_q  <= CNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AMBIENT: amb_q  <= cfg_data_i[ACC_W-1:0];
        REG_GAIN:    gain_q <= cfg_data_i;
        REG_COUNT:   cnt_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign amb_c  = (amb_q > AMB_MAX) ? AMB_MAX : amb_q;
  assign gain_c = (gain_q > GAIN_MAX) ? GAIN_MAX : gain_q;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    tok_in.valid   = in_valid_i;
    tok_in.op      = opcode_i;
    tok_in.slot    = light_slot_i;
    tok_in.dir_x   = signed'(light_dir_x_i);
    tok_in.dir_y   = signed'(light_dir_y_i);
    tok_in.dir_z   = signed'(light_dir_z_i);
    tok_in.power   = light_power_i;
    tok_in.present = voxel_present_i;
    tok_in.red     = voxel_red_i;
    tok_in.green   = voxel_green_i;
    tok_in.blue    = voxel_blue_i;
    tok_in.alpha   = voxel_alpha_i;
    tok_in.norm    = face_normal(exposed_faces_i);
    tok_in.acc     = amb_c;
  end

  assign chain[0] = tok_in;

  for (genvar k = 0; k < MAX_LIGHTS; k++) begin : g_cell
    assign active[k] = CMP_W'(k) < CMP_W'(cnt_q);

    vls_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .active_i   (active[k]),
      .cell_idx_i (IDX_W'(k)),
      .gain_i     (gain_c),
      .tok_i      (chain[k]),
      .tok_o      (chain[k+1])
    );
  end

  vls_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .tok_i       (chain[MAX_LIGHTS]),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .out_alpha_o (out_alpha_o)
  );

endmodule

FILE: bench/voxel_lambert_shader_unit_tb.sv
`timescale 1ns / 1ps

module voxel_lambert_shader_unit_tb;
  import vls_pkg::*;

  localparam int PIPE_DEPTH = 2 * MAX_LIGHTS + 1;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic        op;
    logic [2:0]  slot;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [15:0] dir_z;
    logic [15:0] power;
    logic        present;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [5:0]  faces;
  } voxel_item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } shade_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        opcode_i;
  logic [2:0]  light_slot_i;
  logic [15:0] light_dir_x_i;
  logic [15:0] light_dir_y_i;
  logic [15:0] light_dir_z_i;
  logic [15:0] light_power_i;
  logic        voxel_present_i;
  logic [7:0]  voxel_red_i;
  logic [7:0]  voxel_green_i;
  logic [7:0]  voxel_blue_i;
  logic [7:0]  voxel_alpha_i;
  logic [5:0]  exposed_faces_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        status_o;
  logic [7:0]  out_red_o;
  logic [7:0]  out_green_o;
  logic [7:0]  out_blue_o;
  logic [7:0]  out_alpha_o;

  // Shadow copy of the light slots and registers, updated in transfer order.
  logic signed [15:0] lamp_dir_x [MAX_LIGHTS];
  logic signed [15:0] lamp_dir_y [MAX_LIGHTS];
  logic signed [15:0] lamp_dir_z [MAX_LIGHTS];
  logic [15:0]        lamp_power [MAX_LIGHTS];
  logic [14:0]        ambient_q;
  logic [15:0]        gain_q;
  logic [3:0]         count_q;

  shade_result_t shade_queue[$];
  int            fault_count;
  int            hold_cycles;
  bit            tx_idle;
  bit            rx_idle;

  always #5 clk_i = ~clk_i;

  voxel_lambert_shader_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .light_slot_i    (light_slot_i),
    .light_dir_x_i   (light_dir_x_i),
    .light_dir_y_i   (light_dir_y_i),
    .light_dir_z_i   (light_dir_z_i),
    .light_power_i   (light_power_i),
    .voxel_present_i (voxel_present_i),
    .voxel_red_i     (voxel_red_i),
    .voxel_green_i   (voxel_green_i),
    .voxel_blue_i    (voxel_blue_i),
    .voxel_alpha_i   (voxel_alpha_i),
    .exposed_faces_i (exposed_faces_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .out_red_o       (out_red_o),
    .out_green_o     (out_green_o),
    .out_blue_o      (out_blue_o),
    .out_alpha_o     (out_alpha_o)
  );

  function automatic logic [7:0] dim_channel(logic [7:0] c, longint unsigned total);
    longint unsigned v;
    v = (64'(c) * total) >> 14;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic shade_result_t lit_voxel(voxel_item_t v);
    shade_result_t   r;
    int              sx, sy, sz, axes, mag, lamps;
    longint          dot;
    longint unsigned amb, gain, diffuse, total;
    r = '0;
    if (!v.present) begin
      r.status = ST_MISSING;
      return r;
    end
    sx = int'(v.faces[3]) - int'(v.faces[2]);
    sy = int'(v.faces[0]) - int'(v.faces[1]);
    sz = int'(v.faces[4]) - int'(v.faces[5]);
    axes = int'(sx != 0) + int'(sy != 0) + int'(sz != 0);
    case (axes)
      1:       mag = int'(ONE_Q14);
      2:       mag = int'(INV_SQRT2);
      3:       mag = int'(INV_SQRT3);
      default: mag = 0;
    endcase
    amb = (ambient_q > AMB_MAX) ? AMB_MAX : ambient_q;
    gain = (gain_q > GAIN_MAX) ? GAIN_MAX : gain_q;
    lamps = (count_q > MAX_LIGHTS) ? MAX_LIGHTS : int'(count_q);
    diffuse = 0;
    for (int i = 0; i < lamps; i++) begin
      dot = longint'(sx * mag) * longint'(lamp_dir_x[i]) +
            longint'(sy * mag) * longint'(lamp_dir_y[i]) +
            longint'(sz * mag) * longint'(lamp_dir_z[i]);
      if (dot > 0) begin
        diffuse += (unsigned'(dot) * 64'(lamp_power[i]) * gain) >> 42;
      end
    end
    total = amb + diffuse;
    if (total > TOTAL_MAX) begin
      total = TOTAL_MAX;
    end
    r.status = ST_SHADED;
    r.red    = dim_channel(v.red, total);
    r.green  = dim_channel(v.green, total);
    r.blue   = dim_channel(v.blue, total);
    r.alpha  = v.alpha;
    return r;
  endfunction

  function automatic voxel_item_t shade_of(logic [7:0] red, logic [7:0] green,
                                           logic [7:0] blue, logic [7:0] alpha,
                                           logic [5:0] faces, logic present);
    voxel_item_t v;
    v = '0;
    v.op = OP_SHADE;
    v.present = present;
    v.red = red;
    v.green = green;
    v.blue = blue;
    v.alpha = alpha;
    v.faces = faces;
    return v;
  endfunction

  function automatic voxel_item_t load_of(logic [2:0] slot, logic [15:0] dx,
                                          logic [15:0] dy, logic [15:0] dz,
                                          logic [15:0] power);
    voxel_item_t v;
    v = '0;
    v.op = OP_LOAD;
    v.slot = slot;
    v.dir_x = dx;
    v.dir_y = dy;
    v.dir_z = dz;
    v.power = power;
    return v;
  endfunction

  function automatic logic [15:0] random_dir();
    if ($urandom_range(0, 3) == 0) begin
      return 16'($urandom);
    end
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic voxel_item_t random_item();
    voxel_item_t v;
    v.op      = ($urandom_range(0, 4) == 0) ? OP_LOAD : OP_SHADE;
    v.slot    = 3'($urandom);
    v.dir_x   = random_dir();
    v.dir_y   = random_dir();
    v.dir_z   = random_dir();
    v.power   = 16'($urandom);
    v.present = ($urandom_range(0, 7) != 0);
    v.red     = 8'($urandom);
    v.green   = 8'($urandom);
    v.blue    = 8'($urandom);
    v.alpha   = 8'($urandom);
    v.faces   = 6'($urandom);
    return v;
  endfunction

  task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_AMBIENT: ambient_q = data[14:0];
      REG_GAIN:    gain_q = data;
      REG_COUNT:   count_q = data[3:0];
      default:     ;
    endcase
  endtask

  task automatic offer_item(input voxel_item_t item);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    opcode_i        = item.op;
    light_slot_i    = item.slot;
    light_dir_x_i   = item.dir_x;
    light_dir_y_i   = item.dir_y;
    light_dir_z_i   = item.dir_z;
    light_power_i   = item.power;
    voxel_present_i = item.present;
    voxel_red_i     = item.red;
    voxel_green_i   = item.green;
    voxel_blue_i    = item.blue;
    voxel_alpha_i   = item.alpha;
    exposed_faces_i = item.faces;
    in_valid_i      = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (item.op == OP_LOAD) begin
      lamp_dir_x[item.slot] = item.dir_x;
      lamp_dir_y[item.slot] = item.dir_y;
      lamp_dir_z[item.slot] = item.dir_z;
      lamp_power[item.slot] = item.power;
    end else begin
      shade_queue.push_back(lit_voxel(item));
    end
    @(negedge clk_i);
  endtask

  // Load items give no result, so the row may still be busy once the queue empties.
  task automatic drain_pipeline();
    in_valid_i = 1'b0;
    while (shade_queue.size() != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 4) @(negedge clk_i);
  endtask

  task automatic test_default_registers();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    offer_item(shade_of(8'd255, 8'd255, 8'd255, 8'd255, 6'b000000, 1'b0));
    offer_item(shade_of(8'd255, 8'd255, 8'd255, 8'd255, 6'b000000, 1'b1));
    offer_item(shade_of(8'd0, 8'd0, 8'd0, 8'd0, 6'b111111, 1'b1));
    drain_pipeline();
  endtask

  task automatic test_light_loading();
    offer_item(load_of(3'd0, 16'd16384, 16'd0, 16'd0, 16'hFFFF));
    offer_item(load_of(3'd1, 16'd0, 16'd16384, 16'd0, 16'd16384));
    offer_item(load_of(3'd2, 16'd0, 16'd0, 16'd16384, 16'd16384));
    offer_item(load_of(3'd3, -16'sd16384, -16'sd16384, -16'sd16384, 16'hFFFF));
    offer_item(load_of(3'd4, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));
    offer_item(load_of(3'd5, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF));
    offer_item(load_of(3'd6, 16'd11585, 16'd11585, 16'd0, 16'd32768));
    offer_item(load_of(3'd7, 16'd0, 16'd0, 16'd0, 16'd0));
    drain_pipeline();
  endtask

  task automatic test_register_extremes();
    write_register(REG_AMBIENT, 16'(AMB_MAX));
    write_register(REG_GAIN, GAIN_MAX);
    write_register(REG_COUNT, 16'(MAX_LIGHTS));
    offer_item(shade_of(8'd255, 8'd255, 8'd255, 8'd200, 6'b001000, 1'b1));
    offer_item(shade_of(8'd128, 8'd64, 8'd1, 8'd0, 6'b111111, 1'b1));
    offer_item(shade_of(8'd255, 8'd0, 8'd255, 8'd255, 6'b011001, 1'b1));
    offer_item(shade_of(8'd17, 8'd200, 8'd255, 8'd1, 6'b000101, 1'b1));
    offer_item(shade_of(8'd255, 8'd255, 8'd0, 8'd77, 6'b100110, 1'b1));
    drain_pipeline();
    // Values above the legal range must act as the maximum.
    write_register(REG_AMBIENT, 16'hFFFF);
    write_register(REG_GAIN, 16'hFFFF);
    write_register(REG_COUNT, 16'hFFFF);
    offer_item(shade_of(8'd255, 8'd255, 8'd255, 8'd255, 6'b010000, 1'b1));
    offer_item(shade_of(8'd0, 8'd0, 8'd0, 8'd0, 6'b000010, 1'b0));
    drain_pipeline();
    write_register(REG_AMBIENT, 16'd0);
    write_register(REG_GAIN, 16'd0);
    write_register(REG_COUNT, 16'd1);
    write_register(REG_SPARE, 16'hFFFF);
    offer_item(shade_of(8'd255, 8'd100, 8'd3, 8'd9, 6'b001000, 1'b1));
    offer_item(shade_of(8'd255, 8'd255, 8'd255, 8'd128, 6'b000000, 1'b1));
    drain_pipeline();
  endtask

  task automatic test_random_traffic();
    int          phase;
    logic [15:0] amb_val;
    logic [15:0] gain_val;
    for (phase = 0; phase < 11; phase++) begin
      tx_idle = (phase % 4 == 0) || (phase % 4 == 2);
      rx_idle = (phase % 4 == 0) || (phase % 4 == 3);
      case ($urandom_range(0, 3))
        0:       amb_val = 16'd0;
        1:       amb_val = 16'(AMB_MAX);
        2:       amb_val = 16'($urandom_range(0, 16384));
        default: amb_val = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       gain_val = 16'd0;
        1:       gain_val = GAIN_MAX;
        2:       gain_val = 16'($urandom_range(0, 32768));
        default: gain_val = 16'($urandom);
      endcase
      write_register(REG_AMBIENT, amb_val);
      write_register(REG_GAIN, gain_val);
      write_register(REG_COUNT, {12'($urandom), 4'($urandom_range(0, 15))});
      if ($urandom_range(0, 3) == 0) begin
        write_register(REG_SPARE, 16'($urandom));
      end
      repeat (100) offer_item(random_item());
      drain_pipeline();
    end
  endtask

  task automatic test_output_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_cycles = 80;
    repeat (50) offer_item(random_item());
    drain_pipeline();
  endtask

  initial begin : receiver
    bit took;
    int stall;
    out_ready_i = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      took = out_valid_o && out_ready_i;
      @(negedge clk_i);
      if (took) begin
        stall = rx_idle ? $urandom_range(0, 9) : 0;
      end
      if (hold_cycles > 0) begin
        out_ready_i = 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        out_ready_i = 1'b0;
        stall--;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    shade_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (shade_queue.size() == 0) begin
        $error("Result transfer arrived with no shaded voxel outstanding.");
        fault_count++;
      end else begin
        want = shade_queue.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          fault_count++;
        end
        if (out_red_o !== want.red) begin
          $error("out_red: expected %0d, actual %0d", want.red, out_red_o);
          fault_count++;
        end
        if (out_green_o !== want.green) begin
          $error("out_green: expected %0d, actual %0d", want.green, out_green_o);
          fault_count++;
        end
        if (out_blue_o !== want.blue) begin
          $error("out_blue: expected %0d, actual %0d", want.blue, out_blue_o);
          fault_count++;
        end
        if (out_alpha_o !== want.alpha) begin
          $error("out_alpha: expected %0d, actual %0d", want.alpha, out_alpha_o);
          fault_count++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_AMBIENT;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    opcode_i        = OP_SHADE;
    light_slot_i    = '0;
    light_dir_x_i   = '0;
    light_dir_y_i   = '0;
    light_dir_z_i   = '0;
    light_power_i   = '0;
    voxel_present_i = 1'b0;
    voxel_red_i     = '0;
    voxel_green_i   = '0;
    voxel_blue_i    = '0;
    voxel_alpha_i   = '0;
    exposed_faces_i = '0;
    ambient_q       = AMB_RESET;
    gain_q          = GAIN_RESET;
    count_q         = CNT_RESET;
    fault_count     = 0;
    hold_cycles     = 0;
    tx_idle         = 1'b1;
    rx_idle         = 1'b1;
    for (int i = 0; i < MAX_LIGHTS; i++) begin
      lamp_dir_x[i] = '0;
      lamp_dir_y[i] = '0;
      lamp_dir_z[i] = '0;
      lamp_power[i] = '0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_default_registers();
    test_light_loading();
    test_register_extremes();
    test_random_traffic();
    test_output_backpressure();
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/vls_pkg.sv
hw/rtl/vls_cell.sv
hw/rtl/vls_out.sv
hw/rtl/voxel_lambert_shader_unit.sv
bench/voxel_lambert_shader_unit_tb.sv
